@@ src/utp_pkg.sv @@
// utp_pkg: shared types, codes and the character decode of the uuid text parser
// no dependencies; used by every file under src

package utp_pkg;

  localparam int unsigned UuidChars = 36;
  localparam int unsigned PosW      = 6;

  localparam logic [7:0] ChBrace = 8'h7b;
  localparam logic [7:0] ChDash  = 8'h2d;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_BAD_SEP   = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } out_item_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            brace_checked;
    logic            finished;
    status_t         error_code;
    logic [63:0]     accum_high;
    logic [63:0]     accum_low;
  } parse_state_t;

  // bit 4 set marks a character that is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

  function automatic logic is_dash_place(input logic [PosW-1:0] p);
    return p == PosW'(8) || p == PosW'(13) || p == PosW'(18) || p == PosW'(23);
  endfunction

endpackage

@@ src/utp_step.sv @@
// utp_step: one character step of the parse, purely combinational
// depends on utp_pkg

module utp_step (
  input  utp_pkg::parse_state_t state_cur,
  input  utp_pkg::in_item_t     item,
  output utp_pkg::parse_state_t state_nxt,
  output logic                  emit,
  output utp_pkg::out_item_t    result
);

  utp_pkg::parse_state_t s;
  utp_pkg::status_t      st;
  logic                  skip;
  logic [4:0]            dig;

  always_comb begin
    s    = state_cur;
    emit = 1'b0;
    st   = utp_pkg::ST_OK;
    skip = 1'b0;
    dig  = utp_pkg::hex_decode(item.ch);

    if (item.first) begin
      s.position      = '0;
      s.brace_checked = 1'b0;
      s.finished      = 1'b0;
      s.error_code    = utp_pkg::ST_OK;
      s.accum_high    = '0;
      s.accum_low     = '0;
    end

    if (!s.finished) begin
      if (!s.brace_checked) begin
        s.brace_checked = 1'b1;
        if (item.ch == utp_pkg::ChBrace) begin
          skip = 1'b1;
          if (item.last) begin
            emit = 1'b1;
            st   = utp_pkg::ST_SHORT;
          end
        end
      end

      if (!skip) begin
        if (utp_pkg::is_dash_place(s.position)) begin
          if (item.ch != utp_pkg::ChDash && s.error_code == utp_pkg::ST_OK) begin
            s.error_code = utp_pkg::ST_BAD_SEP;
          end
        end else begin
          if (dig[4]) begin
            if (s.error_code == utp_pkg::ST_OK) begin
              s.error_code = utp_pkg::ST_BAD_DIGIT;
            end
          end
          s.accum_high = {s.accum_high[59:0], s.accum_low[63:60]};
          s.accum_low  = {s.accum_low[59:0], (dig[4] ? 4'h0 : dig[3:0])};
        end
        s.position = s.position + utp_pkg::PosW'(1);

        if (s.position >= utp_pkg::PosW'(utp_pkg::UuidChars)) begin
          emit = 1'b1;
          st   = s.error_code;
        end else if (item.last) begin
          emit = 1'b1;
          st   = utp_pkg::ST_SHORT;
        end
      end

      if (emit) begin
        s.finished = 1'b1;
      end
    end

    state_nxt      = s;
    result.status  = st;
    result.id_high = (st == utp_pkg::ST_OK) ? s.accum_high : 64'h0;
    result.id_low  = (st == utp_pkg::ST_OK) ? s.accum_low : 64'h0;
  end

endmodule

@@ src/uuid_text_parser_top.sv @@
// uuid_text_parser_top: top level of the streaming uuid text parser
// depends on utp_pkg and utp_step
//
// Takes one character per cycle and returns at most one 128-bit uuid result per
// text, for the character that completes or ends it. Characters pass through an
// input register, then one step of decode and 4-bit accumulator shift into the
// result register; the throughput is one item per clock while the result side
// does not stall.

module uuid_text_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output utp_pkg::out_item_t  out_data
);

  logic                  item_valid_r, item_valid_nxt;
  utp_pkg::in_item_t     item_r;
  logic                  out_valid_r, out_valid_nxt;
  utp_pkg::out_item_t    out_r;
  utp_pkg::parse_state_t state_r, state_nxt;
  utp_pkg::out_item_t    step_result;
  logic                  step_emit;
  logic                  adv;

  utp_step u_step (
    .state_cur (state_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .emit      (step_emit),
    .result    (step_result)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !adv;

  always_comb begin
    item_valid_nxt = item_valid_r;
    out_valid_nxt  = out_valid_r;
    if (!in_stall) begin
      item_valid_nxt = in_valid;
    end
    if (adv) begin
      out_valid_nxt = item_valid_r && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.position      <= '0;
      state_r.brace_checked <= 1'b0;
      state_r.finished      <= 1'b1;
      state_r.error_code    <= utp_pkg::ST_OK;
      state_r.accum_high    <= '0;
      state_r.accum_low     <= '0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (adv && item_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (adv && item_valid_r && step_emit) begin
      out_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ src/utp_checker.sv @@
// utp_checker: port-level assertions for uuid_text_parser_top, bound to it below
// depends on utp_pkg

module utp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input utp_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != utp_pkg::ST_OK |->
      out_data.id_high == 64'h0 && out_data.id_low == 64'h0)
    else $error("non-zero value on error result");

  a_rose_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an item two cycles before");

endmodule

bind uuid_text_parser_top utp_checker u_utp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ dv/uuid_text_parser_checker.sv @@
// uuid_text_parser_checker: watches both channels of the uuid text parser, predicts each
// result from the accepted characters and compares it with what the block returns
// depends on utp_pkg

module uuid_text_parser_checker
  import utp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        result_count
);

  logic [5:0]  pos;
  logic        brace_seen;
  logic        done;
  status_t     err;
  logic [63:0] acc_hi;
  logic [63:0] acc_lo;

  out_item_t   expected_uuids [$];
  int          n_fail;
  int          n_checked;

  function automatic logic [4:0] char_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return 5'(c - 8'h30);
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return 5'(c - 8'h61 + 8'd10);
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return 5'(c - 8'h41 + 8'd10);
    end
    return 5'h10;
  endfunction

  function automatic logic at_separator(input logic [5:0] p);
    case (p)
      6'd8, 6'd13, 6'd18, 6'd23: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_parse();
    pos        = '0;
    brace_seen = 1'b0;
    err        = ST_OK;
    acc_hi     = '0;
    acc_lo     = '0;
  endtask

  task automatic parse_char(input in_item_t it, output logic fire, output out_item_t res);
    logic [4:0] nib;
    status_t    st;
    fire = 1'b0;
    st   = ST_OK;
    res  = '0;
    if (it.first) begin
      clear_parse();
      done = 1'b0;
    end
    if (!done) begin
      if (!brace_seen && it.ch == ChBrace) begin
        brace_seen = 1'b1;
        if (it.last) begin
          fire = 1'b1;
          st   = ST_SHORT;
        end
      end else begin
        brace_seen = 1'b1;
        if (at_separator(pos)) begin
          if (it.ch != ChDash && err == ST_OK) begin
            err = ST_BAD_SEP;
          end
        end else begin
          nib = char_nibble(it.ch);
          if (nib[4]) begin
            if (err == ST_OK) begin
              err = ST_BAD_DIGIT;
            end
            nib = '0;
          end
          {acc_hi, acc_lo} = {acc_hi[59:0], acc_lo, nib[3:0]};
        end
        pos = pos + 6'd1;
        if (pos >= 6'(UuidChars)) begin
          fire = 1'b1;
          st   = err;
        end else if (it.last) begin
          fire = 1'b1;
          st   = ST_SHORT;
        end
      end
      if (fire) begin
        done        = 1'b1;
        res.status  = st;
        res.id_high = (st == ST_OK) ? acc_hi : '0;
        res.id_low  = (st == ST_OK) ? acc_lo : '0;
      end
    end
  endtask

  initial begin
    clear_parse();
    done         = 1'b1;
    n_fail       = 0;
    n_checked    = 0;
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    logic      fire;
    out_item_t res;
    out_item_t want;
    if (!rst_n) begin
      clear_parse();
      done = 1'b1;
      expected_uuids.delete();
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(in_data, fire, res);
        if (fire) begin
          expected_uuids.push_back(res);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_uuids.size() == 0) begin
          n_fail++;
          $display("%0t: result with none expected, got status %0d id %h_%h", $time,
                   out_data.status, out_data.id_high, out_data.id_low);
        end else begin
          want = expected_uuids.pop_front();
          n_checked++;
          if (out_data.status !== want.status) begin
            n_fail++;
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data.status);
          end
          if (out_data.id_high !== want.id_high) begin
            n_fail++;
            $display("%0t: id_high expected %h got %h", $time, want.id_high,
                     out_data.id_high);
          end
          if (out_data.id_low !== want.id_low) begin
            n_fail++;
            $display("%0t: id_low expected %h got %h", $time, want.id_low,
                     out_data.id_low);
          end
        end
      end
    end
    fail_count   <= n_fail;
    pending      <= expected_uuids.size();
    result_count <= n_checked;
  end

endmodule

@@ dv/uuid_text_parser_top_test.sv @@
// uuid_text_parser_top_test: drives character texts into the uuid text parser with random
// gaps and result stalls, and gives the verdict from the checker's failure count
// depends on utp_pkg, uuid_text_parser_top and uuid_text_parser_checker

module uuid_text_parser_top_test;
  import utp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChClose = 8'h7d;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int result_count;
  int cycle_count = 0;
  int n_chars     = 0;
  int n_texts     = 0;
  bit calm        = 1'b0;

  logic [7:0] txt [$];

  uuid_text_parser_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  uuid_text_parser_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("uuid_text_parser_top verification failed");
      $finish;
    end
  end

  // result side: a random stall before each item
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    n_chars++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) begin
      return ChZero + 8'(n);
    end
    return (upper ? ChUpA : ChLowA) + 8'(n) - 8'd10;
  endfunction

  // case_mode: 0 lower, 1 upper, 2 mixed
  task automatic make_uuid(input logic [127:0] v, input int case_mode);
    int k;
    bit upper;
    k = 0;
    txt.delete();
    for (int p = 0; p < 36; p++) begin
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        txt.push_back(ChDash);
      end else begin
        upper = (case_mode == 2) ? bit'($urandom_range(0, 1)) : (case_mode == 1);
        txt.push_back(hex_char(v[127 - 4*k -: 4], upper));
        k++;
      end
    end
  endtask

  // last_at below zero or past the end leaves last low throughout
  task automatic play_text(input int last_at);
    in_item_t it;
    n_texts++;
    foreach (txt[i]) begin
      it.ch    = txt[i];
      it.first = (i == 0);
      it.last  = (i == last_at);
      send_item(it);
    end
  endtask

  function automatic logic [127:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [7:0] odd_chars [8];
    in_item_t   it;
    int         kind;
    int         n;
    int         cut;
    bit         braced;

    odd_chars = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hff};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle after reset: ignored until a first
    send_item('{ch: ChZero, first: 1'b0, last: 1'b0});
    send_item('{ch: ChLowA, first: 1'b0, last: 1'b1});

    make_uuid('0, 0);
    play_text(35);
    make_uuid('1, 0);
    txt.push_front(ChBrace);
    txt.push_back(ChClose);
    play_text(37);
    make_uuid('1, 1);
    play_text(-1);
    send_item('{ch: ChUpA, first: 1'b0, last: 1'b1});
    make_uuid(rand_id(), 2);
    txt.push_front(ChBrace);
    play_text(36);

    // brace alone, and a single character, both end too early
    txt = '{ChBrace};
    play_text(0);
    txt = '{ChLowA};
    play_text(0);

    // characters outside the hex ranges, most of them just outside
    for (int t = 0; t < 2; t++) begin
      make_uuid(rand_id(), 2);
      for (int j = 0; j < 4; j++) begin
        txt[j * 9 + 1] = odd_chars[t * 4 + j];
      end
      play_text(35);
    end

    make_uuid(rand_id(), 0);
    txt[8] = 8'h5f;
    play_text(35);
    make_uuid(rand_id(), 1);
    txt[3]  = 8'h78;
    txt[13] = 8'h2b;
    play_text(35);
    make_uuid(rand_id(), 2);
    txt[18] = ChZero;
    txt[30] = 8'h7a;
    play_text(35);

    // an error followed by an early end
    make_uuid(rand_id(), 0);
    txt[2] = 8'h71;
    play_text(20);

    // restart in the middle of a text
    make_uuid(rand_id(), 2);
    txt = txt[0:14];
    play_text(-1);
    make_uuid(rand_id(), 2);
    play_text(35);

    while (n_chars < 1400) begin
      if ($urandom_range(0, 7) == 0) begin
        calm = ~calm;
      end
      kind   = $urandom_range(0, 99);
      braced = bit'($urandom_range(0, 1));
      make_uuid(rand_id(), $urandom_range(0, 2));
      if (kind < 55) begin
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(1, 3);
          repeat (n) txt.push_back($urandom_range(0, 1) ? ChClose : 8'($urandom));
        end
        if (braced) begin
          txt.push_front(ChBrace);
        end
        case ($urandom_range(0, 2))
          0: play_text(txt.size() - 1);
          1: play_text(braced ? 36 : 35);
          default: play_text(-1);
        endcase
      end else if (kind < 70) begin
        n = $urandom_range(1, 3);
        repeat (n) txt[$urandom_range(0, 35)] = 8'($urandom);
        if (braced) begin
          txt.push_front(ChBrace);
        end
        play_text(txt.size() - 1);
      end else if (kind < 93) begin
        if ($urandom_range(0, 2) == 0) begin
          txt[$urandom_range(0, 35)] = 8'($urandom);
        end
        cut = $urandom_range(1, 35);
        txt = txt[0:cut - 1];
        if (braced) begin
          txt.push_front(ChBrace);
        end
        play_text(kind < 85 ? txt.size() - 1 : -1);
      end else begin
        n = $urandom_range(1, 40);
        for (int j = 0; j < n; j++) begin
          it.ch    = 8'($urandom);
          it.first = ($urandom_range(0, 7) == 0);
          it.last  = ($urandom_range(0, 7) == 0);
          send_item(it);
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("sent %0d texts plus noise, %0d characters in all", n_texts, n_chars);
    $display("checked %0d results against the predicted uuids", result_count);
    if (fail_count == 0) begin
      $display("uuid_text_parser_top verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("uuid_text_parser_top verification failed");
    end
    $finish;
  end

endmodule
